>>> hdl/matrix_vector_multiply_f32_assert.svh
// Assertion macros for the matrix-vector block.
// Each expects clk and rst_n in scope.
`ifndef MATRIX_VECTOR_MULTIPLY_F32_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_F32_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define MVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define MVM_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

>>> hdl/mvm_pkg.sv
package mvm_pkg;

    localparam int NUM_COLS_W = 13;
    localparam int NUM_ROWS_W = 16;
    localparam int FP_W       = 32;

    localparam logic [FP_W-1:0] FP_QNAN     = 32'h7FC0_0000;
    localparam logic [FP_W-1:0] FP_POS_ZERO = 32'h0000_0000;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_WEIGHT = 1'b1
    } mvm_cmd_t;

    typedef enum logic
    {
        REG_NUM_COLS = 1'b0,
        REG_NUM_ROWS = 1'b1
    } mvm_reg_t;

    // Row bookkeeping that travels with each weight.
    typedef struct packed
    {
        logic                  row_end;
        logic [NUM_ROWS_W-1:0] row_number;
        logic                  last;
    } mvm_tag_t;

endpackage

>>> hdl/mvm_item_if.sv
interface mvm_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

>>> hdl/mvm_result_if.sv
interface mvm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_sum;
    logic [15:0] row_number;
    logic        last_row;

    modport source (output valid, output row_sum, output row_number, output last_row,
                    input ready);
    modport sink (input valid, input row_sum, input row_number, input last_row,
                  output ready);
endinterface

>>> hdl/mvm_ram.sv
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/mvm_fmul.sv
// Two-stage binary32 multiplier, round to nearest even, NaN made canonical.
module mvm_fmul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    input  mvm_pkg::mvm_tag_t in_tag,
    output logic              out_valid,
    output logic [31:0]       prod,
    output mvm_pkg::mvm_tag_t out_tag
);

    // stage A: significand product
    logic [7:0]         ea, eb;
    logic [23:0]        ma, mb;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic               valid_a_reg;
    logic               sign_a_reg, sign_a_next;
    logic               nan_a_reg, nan_a_next;
    logic               inf_a_reg, inf_a_next;
    logic signed [10:0] exp_a_reg, exp_a_next;
    logic [47:0]        p_a_reg, p_a_next;
    mvm_pkg::mvm_tag_t  tag_a_reg;

    // stage B: normalize and round
    logic [5:0]         lz;
    logic signed [10:0] er;
    logic [10:0]        k;
    logic [47:0]        n, t;
    logic               lost, g, st, inc;
    logic [7:0]         expf;
    logic [23:0]        sig;
    logic [30:0]        packed_v;
    logic [31:0]        prod_next;
    logic               valid_b_reg;
    logic [31:0]        prod_reg;
    mvm_pkg::mvm_tag_t  tag_b_reg;

    always_comb
    begin
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {|a[30:23], a[22:0]};
        mb     = {|b[30:23], b[22:0]};
        nan_a  = (&a[30:23]) && (|a[22:0]);
        nan_b  = (&b[30:23]) && (|b[22:0]);
        inf_a  = (&a[30:23]) && !(|a[22:0]);
        inf_b  = (&b[30:23]) && !(|b[22:0]);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);

        sign_a_next = a[31] ^ b[31];
        nan_a_next  = nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);
        inf_a_next  = inf_a || inf_b;
        exp_a_next  = signed'({3'b000, ea}) + signed'({3'b000, eb}) - 11'sd127;
        p_a_next    = ma * mb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_a_reg <= sign_a_next;
            nan_a_reg  <= nan_a_next;
            inf_a_reg  <= inf_a_next;
            exp_a_reg  <= exp_a_next;
            p_a_reg    <= p_a_next;
            tag_a_reg  <= in_tag;
            prod_reg   <= prod_next;
            tag_b_reg  <= tag_a_reg;
        end
    end

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (p_a_reg[i])
            begin
                lz = 6'(47 - i);
            end
        end
        er   = exp_a_reg + 11'sd1 - signed'({5'b00000, lz});
        n    = p_a_reg << lz;
        k    = 11'd0;
        t    = n;
        lost = 1'b0;
        expf = 8'd0;
        if (er >= 11'sd1)
        begin
            expf = er[7:0];
        end
        else
        begin
            k = unsigned'(11'sd1 - er);
            if (k >= 11'd48)
            begin
                t    = 48'd0;
                lost = 1'b1;
            end
            else
            begin
                t    = n >> k;
                lost = |(n & ((48'd1 << k) - 48'd1));
            end
        end
        sig      = t[47:24];
        g        = t[23];
        st       = (|t[22:0]) || lost;
        inc      = g && (st || sig[0]);
        packed_v = {expf, sig[22:0]} + 31'(inc);

        if (nan_a_reg)
        begin
            prod_next = mvm_pkg::FP_QNAN;
        end
        else if (inf_a_reg || (er >= 11'sd255 && p_a_reg != 48'd0))
        begin
            prod_next = {sign_a_reg, 8'hFF, 23'd0};
        end
        else if (p_a_reg == 48'd0)
        begin
            prod_next = {sign_a_reg, 31'd0};
        end
        else
        begin
            prod_next = {sign_a_reg, packed_v};
        end
    end

    assign out_valid = valid_b_reg;
    assign prod      = prod_reg;
    assign out_tag   = tag_b_reg;

endmodule

>>> hdl/mvm_accum.sv
// Combinational binary32 adder closing the running-sum loop, plus the result register.
module mvm_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       prod,
    input  mvm_pkg::mvm_tag_t in_tag,
    output logic              stall,
    mvm_result_if.source      result
);

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic        a_nan, b_nan, a_inf, b_inf, sub, g, st, inc;
        logic [31:0] x, y;
        logic [7:0]  ex, ey, d, sh, exm1;
        logic [23:0] mx, my;
        logic [26:0] ax, ay, r;
        logic [27:0] s;
        logic [4:0]  lz;
        logic [8:0]  e;
        logic [30:0] packed_v;
        a_nan = (&a[30:23]) && (|a[22:0]);
        b_nan = (&b[30:23]) && (|b[22:0]);
        a_inf = (&a[30:23]) && !(|a[22:0]);
        b_inf = (&b[30:23]) && !(|b[22:0]);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
        begin
            return mvm_pkg::FP_QNAN;
        end
        if (a_inf)
        begin
            return a;
        end
        if (b_inf)
        begin
            return b;
        end
        if (a[30:0] >= b[30:0])
        begin
            x = a;
            y = b;
        end
        else
        begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {|x[30:23], x[22:0]};
        my = {|y[30:23], y[22:0]};
        d  = ex - ey;
        ax = {mx, 3'b000};
        if (d >= 8'd27)
        begin
            ay = {26'd0, |my};
        end
        else
        begin
            ay    = {my, 3'b000} >> d;
            ay[0] = ay[0] | (|({my, 3'b000} & ((27'd1 << d) - 27'd1)));
        end
        sub = x[31] ^ y[31];
        s   = sub ? ({1'b0, ax} - {1'b0, ay}) : ({1'b0, ax} + {1'b0, ay});
        if (s == 28'd0)
        begin
            return sub ? mvm_pkg::FP_POS_ZERO : {x[31], 31'd0};
        end
        if (s[27])
        begin
            r    = s[27:1];
            r[0] = s[1] | s[0];
            e    = {1'b0, ex} + 9'd1;
        end
        else
        begin
            lz = 5'd0;
            for (int i = 0; i < 27; i++)
            begin
                if (s[i])
                begin
                    lz = 5'(26 - i);
                end
            end
            exm1 = ex - 8'd1;
            sh   = ({3'b000, lz} < exm1) ? {3'b000, lz} : exm1;
            r    = s[26:0] << sh;
            e    = {1'b0, ex} - {1'b0, sh};
        end
        if (e >= 9'd255)
        begin
            return {x[31], 8'hFF, 23'd0};
        end
        g        = r[2];
        st       = |r[1:0];
        inc      = g && (st || r[3]);
        packed_v = {(r[26] ? e[7:0] : 8'd0), r[25:3]} + 31'(inc);
        return {x[31], packed_v};
    endfunction

    logic [31:0]       acc_reg, acc_next;
    logic [31:0]       sum;
    logic              out_valid_reg;
    logic [31:0]       row_sum_reg;
    mvm_pkg::mvm_tag_t out_tag_reg;
    logic              take;

    assign sum   = fp_add(acc_reg, prod);
    assign take  = en && in_valid;
    // only a finishing row waits on the result register
    assign stall = out_valid_reg && !result.ready && in_valid && in_tag.row_end;

    always_comb
    begin
        acc_next = acc_reg;
        if (take)
        begin
            acc_next = in_tag.row_end ? mvm_pkg::FP_POS_ZERO : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= mvm_pkg::FP_POS_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (take && in_tag.row_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_tag.row_end)
        begin
            row_sum_reg <= sum;
            out_tag_reg <= in_tag;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.row_sum    = row_sum_reg;
    assign result.row_number = out_tag_reg.row_number;
    assign result.last_row   = out_tag_reg.last;

endmodule

>>> hdl/matrix_vector_multiply_f32.sv
// Streaming binary32 matrix-vector product (y = W * x).
// Channel "item": cmd=0 loads the next vector element into the vector RAM,
// cmd=1 supplies the next weight, row by row. Channel "result": one request
// per finished row with row_sum, row_number and last_row.
// Both channels use valid/ready; a transfer happens when both are high.
// APB port: num_cols at byte 0, num_rows at byte 4; write only while idle.
// Throughput: one item per cycle while not stalled, loads and weights alike, set by
// the combinational add that closes the running-sum loop.
// A row result passes the RAM read with weight register, the multiply, the
// round and the accumulate into the result register, each registered.
// Reset: pointers to zero, running sum to +0.0, num_cols = num_rows = 1.
// The vector RAM is not cleared; load elements before weights use them.
// Receiver stall: the pipeline keeps taking items until a finished row
// reaches the result register while it is still full; then item.ready
// drops until the pending request is taken.
module matrix_vector_multiply_f32 #(
    parameter int MAX_COLS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mvm_item_if.sink    item,
    mvm_result_if.source result
);

    localparam int PW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int EW   = (CW > mvm_pkg::NUM_COLS_W) ? CW : mvm_pkg::NUM_COLS_W;
    localparam int RW   = mvm_pkg::NUM_ROWS_W;

    logic [mvm_pkg::NUM_COLS_W-1:0] num_cols_reg;
    logic [RW-1:0]                  num_rows_reg;
    logic [EW-1:0]                  eff_cols;
    logic [RW:0]                    eff_rows;

    logic [PW-1:0]     load_ptr_reg, load_ptr_next;
    logic [PW-1:0]     col_ptr_reg, col_ptr_next;
    logic [RW-1:0]     row_ptr_reg, row_ptr_next;

    logic              stall, en, accept;
    logic              is_weight, col_end, row_last;
    logic              ram_we, ram_re;
    logic [31:0]       ram_rdata;

    logic              s1_valid_reg;
    logic [31:0]       s1_weight_reg;
    mvm_pkg::mvm_tag_t s1_tag_reg, s1_tag_next;

    logic              mul_valid;
    logic [31:0]       mul_prod;
    mvm_pkg::mvm_tag_t mul_tag;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= mvm_pkg::NUM_COLS_W'(1);
            num_rows_reg <= RW'(1);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (mvm_pkg::mvm_reg_t'(paddr[2]))
                mvm_pkg::REG_NUM_COLS: num_cols_reg <= pwdata[mvm_pkg::NUM_COLS_W-1:0];
                mvm_pkg::REG_NUM_ROWS: num_rows_reg <= pwdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mvm_pkg::mvm_reg_t'(paddr[2]))
            mvm_pkg::REG_NUM_COLS: prdata = 32'(num_cols_reg);
            mvm_pkg::REG_NUM_ROWS: prdata = 32'(num_rows_reg);
            default:               prdata = 32'd0;
        endcase
    end

    // zero acts as one, oversize clamps to the RAM depth
    always_comb
    begin
        if (num_cols_reg == '0)
        begin
            eff_cols = EW'(1);
        end
        else if (EW'(num_cols_reg) > EW'(MAX_COLS))
        begin
            eff_cols = EW'(MAX_COLS);
        end
        else
        begin
            eff_cols = EW'(num_cols_reg);
        end
        eff_rows = (num_rows_reg == '0) ? (RW + 1)'(1) : (RW + 1)'(num_rows_reg);
    end

    // ---------------- front end: pointers ----------------
    assign en         = !stall;
    assign item.ready = en;
    assign accept     = item.valid && item.ready;
    assign is_weight  = (mvm_pkg::mvm_cmd_t'(item.cmd) == mvm_pkg::CMD_WEIGHT);
    assign ram_we     = accept && !is_weight;
    assign ram_re     = accept && is_weight;
    assign col_end    = (EW'(col_ptr_reg) + EW'(1)) >= eff_cols;
    assign row_last   = ((RW + 1)'(row_ptr_reg) + (RW + 1)'(1)) >= eff_rows;

    always_comb
    begin
        load_ptr_next = load_ptr_reg;
        col_ptr_next  = col_ptr_reg;
        row_ptr_next  = row_ptr_reg;
        if (ram_we)
        begin
            load_ptr_next = ((EW'(load_ptr_reg) + EW'(1)) >= eff_cols) ? '0
                                                                       : load_ptr_reg + PW'(1);
        end
        if (ram_re)
        begin
            col_ptr_next = col_end ? '0 : col_ptr_reg + PW'(1);
            if (col_end)
            begin
                row_ptr_next = row_last ? '0 : row_ptr_reg + RW'(1);
            end
        end
        s1_tag_next.row_end    = col_end;
        s1_tag_next.row_number = row_ptr_reg;
        s1_tag_next.last       = row_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            col_ptr_reg  <= '0;
            row_ptr_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            load_ptr_reg <= load_ptr_next;
            col_ptr_reg  <= col_ptr_next;
            row_ptr_reg  <= row_ptr_next;
            if (en)
            begin
                s1_valid_reg <= ram_re;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_weight_reg <= item.value;
            s1_tag_reg    <= s1_tag_next;
        end
    end

    // ---------------- vector store ----------------
    // Read data is held while stalled since ram_re is low then.
    mvm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_ptr_reg),
        .wdata (item.value),
        .re    (ram_re),
        .raddr (col_ptr_reg),
        .rdata (ram_rdata)
    );

    // ---------------- multiply, accumulate ----------------
    mvm_fmul u_fmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .a         (s1_weight_reg),
        .b         (ram_rdata),
        .in_tag    (s1_tag_reg),
        .out_valid (mul_valid),
        .prod      (mul_prod),
        .out_tag   (mul_tag)
    );

    mvm_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mul_valid),
        .prod     (mul_prod),
        .in_tag   (mul_tag),
        .stall    (stall),
        .result   (result)
    );

    // ---------------- checks ----------------
`include "matrix_vector_multiply_f32_assert.svh"

    `MVM_ASSERT(a_ram_one_port, !(ram_we && ram_re), "vector RAM read and written together")
    `MVM_ASSERT(a_stall_no_access, !stall || (!ram_we && !ram_re), "RAM access while stalled")
    `MVM_ASSERT_NEXT(a_stall_freeze, stall, $stable(s1_tag_reg), "front stage moved in stall")
    `MVM_ASSERT(a_last_row, !(result.valid && result.last_row) || ((RW + 1)'(result.row_number) + (RW + 1)'(1) >= eff_rows), "last_row on an inner row")

endmodule

>>> tb/sv/mvm_row_checker.sv
// Watches the item, result and register ports, predicts every row sum and
// compares each result request with the oldest expected row.
module mvm_row_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    mvm_item_if         item,
    mvm_result_if       result,
    output int          mismatches,
    output int          rows_pending
);

    localparam int VEC_DEPTH = 4096;

    typedef struct {
        logic [mvm_pkg::FP_W-1:0]       sum;
        logic [mvm_pkg::NUM_ROWS_W-1:0] row;
        logic                           last;
    } row_result_t;

    row_result_t                    expected_rows[$];
    logic [mvm_pkg::FP_W-1:0]       vec_mem [0:VEC_DEPTH-1];
    int                             ld_ptr;
    int                             col_ptr;
    int                             row_ptr;
    logic [mvm_pkg::FP_W-1:0]       acc;
    logic [mvm_pkg::NUM_COLS_W-1:0] cfg_cols;
    logic [mvm_pkg::NUM_ROWS_W-1:0] cfg_rows;

    // Round sig * 2^x to binary32, nearest-even, with subnormals.
    function automatic logic [31:0] fp_round(logic sgn, logic [71:0] sig, int x);
        int          n;
        int          lsb_e;
        int          sh;
        int          biased;
        logic [71:0] q;
        logic [71:0] rem;
        logic [71:0] half;
        if (sig == 0)
        begin
            return {sgn, 31'd0};
        end
        n = 71;
        while (!sig[n])
        begin
            n--;
        end
        lsb_e = n + x - 23;
        if (lsb_e < -149)
        begin
            lsb_e = -149;
        end
        sh = lsb_e - x;
        if (sh <= 0)
        begin
            q = sig << (-sh);
        end
        else if (sh > 72)
        begin
            q = 0;
        end
        else
        begin
            q    = sig >> sh;
            rem  = sig & ((72'd1 << sh) - 72'd1);
            half = 72'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 72'd1;
            end
        end
        if (q[24])
        begin
            q = q >> 1;
            lsb_e++;
        end
        if (!q[23])
        begin
            return {sgn, 8'd0, q[22:0]};
        end
        biased = lsb_e + 150;
        if (biased >= 255)
        begin
            return {sgn, 8'hFF, 23'd0};
        end
        return {sgn, biased[7:0], q[22:0]};
    endfunction

    function automatic logic is_nan(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 0;
    endfunction

    function automatic logic is_inf(logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] == 0;
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic sgn;
        int   ea;
        int   eb;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b))
        begin
            return mvm_pkg::FP_QNAN;
        end
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
        begin
            return mvm_pkg::FP_QNAN;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {sgn, 8'hFF, 23'd0};
        end
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        return fp_round(sgn, 72'({a[30:23] != 0, a[22:0]}) * 72'({b[30:23] != 0, b[22:0]}),
                        ea + eb - 300);
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lil;
        logic [71:0] mb;
        logic [71:0] ml;
        logic [71:0] sig;
        int          eb;
        int          el;
        int          d;
        int          x;
        logic        sgn;
        if (is_nan(a) || is_nan(b))
        begin
            return mvm_pkg::FP_QNAN;
        end
        if (is_inf(a) && is_inf(b))
        begin
            return (a[31] != b[31]) ? mvm_pkg::FP_QNAN : a;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        big = (a[30:0] >= b[30:0]) ? a : b;
        lil = (a[30:0] >= b[30:0]) ? b : a;
        eb  = (big[30:23] == 0) ? 1 : int'(big[30:23]);
        el  = (lil[30:23] == 0) ? 1 : int'(lil[30:23]);
        mb  = 72'({big[30:23] != 0, big[22:0]});
        ml  = 72'({lil[30:23] != 0, lil[22:0]});
        d   = eb - el;
        if (d > 40)
        begin
            // far smaller operand only matters as a sticky bit
            mb = mb << 3;
            ml = (ml != 0) ? 72'd1 : 72'd0;
            x  = eb - 153;
        end
        else
        begin
            mb = mb << d;
            x  = el - 150;
        end
        if (a[31] == b[31])
        begin
            sig = mb + ml;
            sgn = a[31];
        end
        else
        begin
            sig = mb - ml;
            sgn = (sig == 0) ? 1'b0 : big[31];
        end
        return fp_round(sgn, sig, x);
    endfunction

    function automatic int bump(int p, int bound);
        return (p + 1 >= bound) ? 0 : p + 1;
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch @%0t: %s", $time, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int          cols;
        int          rows;
        logic        last;
        row_result_t want;
        if (!rst_n)
        begin
            expected_rows.delete();
            ld_ptr       = 0;
            col_ptr      = 0;
            row_ptr      = 0;
            acc          = mvm_pkg::FP_POS_ZERO;
            cfg_cols     = 1;
            cfg_rows     = 1;
            mismatches   = 0;
            rows_pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (mvm_pkg::mvm_reg_t'(paddr[2]) == mvm_pkg::REG_NUM_COLS)
                begin
                    cfg_cols = pwdata[mvm_pkg::NUM_COLS_W-1:0];
                end
                else
                begin
                    cfg_rows = pwdata[mvm_pkg::NUM_ROWS_W-1:0];
                end
            end

            // result first: it always belongs to an earlier weight
            if (result.valid && result.ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected row %0d sum %h",
                                            result.row_number, result.row_sum));
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (want.sum !== result.row_sum || want.row !== result.row_number
                        || want.last !== result.last_row)
                    begin
                        flag_mismatch($sformatf(
                            "exp sum %h row %0d last %0d, got sum %h row %0d last %0d",
                            want.sum, want.row, want.last,
                            result.row_sum, result.row_number, result.last_row));
                    end
                end
            end

            if (item.valid && item.ready)
            begin
                cols = (cfg_cols == 0) ? 1 : (cfg_cols > VEC_DEPTH) ? VEC_DEPTH : int'(cfg_cols);
                rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
                if (mvm_pkg::mvm_cmd_t'(item.cmd) == mvm_pkg::CMD_LOAD)
                begin
                    vec_mem[ld_ptr] = item.value;
                    ld_ptr = bump(ld_ptr, cols);
                end
                else
                begin
                    acc = fp_add(acc, fp_mul(item.value, vec_mem[col_ptr]));
                    if (col_ptr + 1 >= cols)
                    begin
                        last = (row_ptr + 1 >= rows);
                        want.sum  = acc;
                        want.row  = row_ptr[mvm_pkg::NUM_ROWS_W-1:0];
                        want.last = last;
                        expected_rows.push_back(want);
                        acc     = mvm_pkg::FP_POS_ZERO;
                        col_ptr = 0;
                        row_ptr = last ? 0 : row_ptr + 1;
                    end
                    else
                    begin
                        col_ptr++;
                    end
                end
            end
            rows_pending = expected_rows.size();
        end
    end

endmodule

>>> tb/sv/matrix_vector_multiply_f32_tb.sv
// Top level: clock, reset, register writes and item/result traffic.
// All checking lives in mvm_row_checker; this module only drives and
// delivers the verdict.
module matrix_vector_multiply_f32_tb;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int VEC_DEPTH   = 4096;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 8;    // settle time after the last row, with margin

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          rows_pending;
    int          cycles;

    // quiet: last stretch of the run, no idling on either side
    logic        quiet;
    logic        hold_on;
    int          ready_gap;
    event        hold_trigger;

    // mirror of the block's pointers, used only to keep weights off
    // vector entries that were never loaded
    logic        loaded [0:VEC_DEPTH-1];
    int          ld_ptr;
    int          col_ptr;
    int          cols_eff;

    mvm_item_if   item_ch();
    mvm_result_if result_ch();

    matrix_vector_multiply_f32 uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    mvm_row_checker row_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item         (item_ch),
        .result       (result_ch),
        .mismatches   (mismatches),
        .rows_pending (rows_pending)
    );

    always #1 clk = ~clk;

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long receiver hold-off: lets the block fill up and stall its input
    always @(hold_trigger)
    begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Result-side backpressure: ready drops for random bursts
    always @(posedge clk)
    begin
        if (ready_gap > 0)
        begin
            ready_gap        <= ready_gap - 1;
            result_ch.ready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            ready_gap        <= $urandom_range(1, 13) - 1;
            result_ch.ready  <= 1'b0;
        end
        else
        begin
            result_ch.ready  <= !hold_on;
        end
    end

    function automatic int bump(int p, int bound);
        return (p + 1 >= bound) ? 0 : p + 1;
    endfunction

    // Mostly moderate magnitudes so rows carry real sums; some specials.
    function automatic logic [31:0] rand_fp();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 19))
            0:       v = {v[31], 31'd0};                     // signed zero
            1:       v = {v[31], 8'hFF, 23'd0};              // infinity
            2:       v = {v[31], 8'hFF, v[22:0] | 23'd1};    // NaN
            3:       v = {v[31], 8'd0, v[22:0]};             // subnormal
            4:       v = {v[31], 8'hFE, v[22:0]};            // near overflow
            5, 6, 7: ;                                       // any bits
            default: v[30:23] = 8'($urandom_range(118, 136));
        endcase
        return v;
    endfunction

    // Drive one request and wait for it to be taken. valid stays high
    // afterwards so back-to-back requests follow without a gap.
    task automatic send(mvm_pkg::mvm_cmd_t op, logic [31:0] val);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd   <= op;
        item_ch.value <= val;
        // ready only moves at the clock edge, so it is stable at negedge
        do
        begin
            @(negedge clk);
        end
        while (!item_ch.ready);
        @(posedge clk);
        if (op == mvm_pkg::CMD_LOAD)
        begin
            loaded[ld_ptr] = 1'b1;
            ld_ptr = bump(ld_ptr, cols_eff);
        end
        else
        begin
            col_ptr = bump(col_ptr, cols_eff);
        end
    endtask

    // A weight aimed at an unloaded entry becomes a load instead.
    task automatic feed(mvm_pkg::mvm_cmd_t op, logic [31:0] val);
        if (op == mvm_pkg::CMD_WEIGHT && !loaded[col_ptr])
        begin
            op = mvm_pkg::CMD_LOAD;
        end
        send(op, val);
    endtask

    // Stop sending and let every outstanding row come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        wait (rows_pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(mvm_pkg::mvm_reg_t idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_shape(int ncols, int nrows);
        drain();
        reg_write(mvm_pkg::REG_NUM_COLS, ncols);
        reg_write(mvm_pkg::REG_NUM_ROWS, nrows);
        cols_eff = (ncols == 0) ? 1 : (ncols > VEC_DEPTH) ? VEC_DEPTH : ncols;
    endtask

    // Well-formed traffic: full vector load, then whole rows, with
    // occasional vector reloads and about one stray request in ten.
    // Stray requests leave pointers mid-row, so the next register
    // write lands mid-stream.
    task automatic run_phase(int ncols, int nrows, int budget, bit squeeze);
        int sent;
        set_shape(ncols, nrows);
        if (squeeze)
        begin
            -> hold_trigger;
        end
        sent = 0;
        for (int i = 0; i < cols_eff; i++)
        begin
            feed(mvm_pkg::CMD_LOAD, rand_fp());
        end
        sent += cols_eff;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                feed(mvm_pkg::mvm_cmd_t'($urandom_range(0, 1)), rand_fp());
                sent++;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                for (int i = 0; i < cols_eff; i++)
                begin
                    feed(mvm_pkg::CMD_LOAD, rand_fp());
                end
                sent += cols_eff;
            end
            else
            begin
                for (int i = 0; i < cols_eff; i++)
                begin
                    feed(mvm_pkg::CMD_WEIGHT, rand_fp());
                end
                sent += cols_eff;
            end
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        item_ch.valid   = 1'b0;
        item_ch.cmd     = mvm_pkg::CMD_LOAD;
        item_ch.value   = '0;
        result_ch.ready = 1'b0;
        quiet           = 1'b0;
        hold_on         = 1'b0;
        ready_gap       = 0;
        cycles          = 0;
        ld_ptr          = 0;
        col_ptr         = 0;
        cols_eff        = 1;
        for (int i = 0; i < VEC_DEPTH; i++)
        begin
            loaded[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset shape (one column, one row): every weight
        // closes a row. Element then weight.
        send(mvm_pkg::CMD_LOAD, 32'h3F80_0000);   send(mvm_pkg::CMD_WEIGHT, 32'h3F80_0000);
        send(mvm_pkg::CMD_LOAD, 32'h7F7F_FFFF);   send(mvm_pkg::CMD_WEIGHT, 32'h7F7F_FFFF);
        send(mvm_pkg::CMD_LOAD, 32'h7F80_0000);   send(mvm_pkg::CMD_WEIGHT, 32'h0000_0000);
        send(mvm_pkg::CMD_LOAD, 32'h7FC0_0001);   send(mvm_pkg::CMD_WEIGHT, 32'h3F80_0000);
        send(mvm_pkg::CMD_LOAD, 32'h0000_0001);   send(mvm_pkg::CMD_WEIGHT, 32'h3F00_0000);
        send(mvm_pkg::CMD_LOAD, 32'h0000_0003);   send(mvm_pkg::CMD_WEIGHT, 32'h3F00_0000);
        send(mvm_pkg::CMD_LOAD, 32'h8000_0000);   send(mvm_pkg::CMD_WEIGHT, 32'h3F80_0000);
        send(mvm_pkg::CMD_LOAD, 32'hFF80_0000);   send(mvm_pkg::CMD_WEIGHT, 32'hFF80_0000);
        send(mvm_pkg::CMD_LOAD, 32'h0080_0000);   send(mvm_pkg::CMD_WEIGHT, 32'h3F7F_FFFF);
        send(mvm_pkg::CMD_LOAD, 32'hFFFF_FFFF);   send(mvm_pkg::CMD_WEIGHT, 32'h3F80_0000);

        // Two-column rows: infinities cancel to NaN, equal terms to +0
        set_shape(2, 2);
        send(mvm_pkg::CMD_LOAD, 32'h3F80_0000);   send(mvm_pkg::CMD_LOAD, 32'h3F80_0000);
        send(mvm_pkg::CMD_WEIGHT, 32'h7F80_0000); send(mvm_pkg::CMD_WEIGHT, 32'hFF80_0000);
        send(mvm_pkg::CMD_WEIGHT, 32'h3FC0_0000); send(mvm_pkg::CMD_WEIGHT, 32'hBFC0_0000);

        // Random part; zero register values act as one
        run_phase(3, 2, 60, 1'b0);
        run_phase(0, 0, 30, 1'b0);
        run_phase(5, 65535, 70, 1'b0);
        run_phase(1, 3, 80, 1'b1);       // long result hold-off
        run_phase(24, 2, 60, 1'b0);
        run_phase(16, 4, 64, 1'b0);
        feed(mvm_pkg::CMD_WEIGHT, rand_fp());
        feed(mvm_pkg::CMD_WEIGHT, rand_fp());
        run_phase(7, 0, 60, 1'b0);       // shape change with a row half done
        run_phase(2, 5, 60, 1'b0);
        quiet = 1'b1;
        run_phase(4, 3, 60, 1'b0);

        item_ch.valid <= 1'b0;
        wait (rows_pending == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
